FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Flag a condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
// Check a property sampled on the rising clock edge.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`endif

`endif

FILE: src/ndsg_pkg.sv
// ----------------------------------------------------------------------------
// ndsg_pkg
// Types and constants shared by the slice gather address generator.
// ----------------------------------------------------------------------------
package ndsg_pkg;

  localparam int MAX_DIMS      = 4;
  localparam int MAX_LIST_LEN  = 16;
  localparam int INDEX_BITS    = 12;

  localparam int DIM_BITS      = $clog2(MAX_DIMS);
  localparam int POS_BITS      = $clog2(MAX_LIST_LEN);
  localparam int LEN_BITS      = $clog2(MAX_LIST_LEN + 1);
  localparam int DIMS_W        = $clog2(MAX_DIMS + 1);
  localparam int RAM_DEPTH     = MAX_DIMS * MAX_LIST_LEN;
  localparam int RAM_ADDR_BITS = DIM_BITS + POS_BITS;

  localparam int EXT_BITS      = 13;
  localparam int SRC_BITS      = 48;
  localparam int DEST_BITS     = 16;
  localparam int WVAL_BITS     = 12;
  localparam int CFG_DIMS_BITS = 3;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - 2;
  localparam int CFG_DATA_BITS = 32;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // Input operation codes
  localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
  localparam logic [1:0] OP_SET_LEN     = 2'd1;
  localparam logic [1:0] OP_REWIND      = 2'd2;
  localparam logic [1:0] OP_STEP        = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DIMS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT3 = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  dim_select;
    logic [3:0]  list_position;
    logic [11:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [SRC_BITS-1:0]  src_offset;
    logic [DEST_BITS-1:0] dest_offset;
    logic                 out_of_range;
    logic                 last;
  } out_item_t;

  typedef logic [MAX_DIMS-1:0][EXT_BITS-1:0] ext_vec_t;
  typedef logic [MAX_DIMS-1:0][POS_BITS-1:0] pos_vec_t;

  // One step waiting for the offset datapath
  typedef struct packed {
    pos_vec_t             pos;
    logic [DEST_BITS-1:0] dest;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic                     we;
    logic [RAM_ADDR_BITS-1:0] addr;
    logic [INDEX_BITS-1:0]    data;
  } ram_wr_t;

  typedef struct packed {
    logic q_full;
    logic drained;
  } front_stall_t;

endpackage

FILE: src/ndsg_ram.sv
// ----------------------------------------------------------------------------
// ndsg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ndsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: src/ndsg_queue.sv
// ----------------------------------------------------------------------------
// ndsg_queue
// Short job queue between the odometer front and the offset back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndsg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ndsg_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output ndsg_pkg::job_t dout,
  output logic          empty
);
  import ndsg_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `ASSERT_NEVER(a_q_push_full, clk, rst_n, push && full, "job pushed into full queue")
  `ASSERT_NEVER(a_q_pop_empty, clk, rst_n, pop && empty, "job popped from empty queue")

endmodule

FILE: src/ndsg_front.sv
// ----------------------------------------------------------------------------
// ndsg_front
// Input stage: holds one transaction, applies list writes, lengths, rewinds
// and advances the odometer, and queues steps for the offset datapath.
// ----------------------------------------------------------------------------
module ndsg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ndsg_pkg::in_item_t           in_data,
  input  logic                         push,
  output logic                         full,
  input  logic [ndsg_pkg::DIMS_W-1:0]  dims,
  input  ndsg_pkg::front_stall_t       stall,
  output logic                         q_push,
  output ndsg_pkg::job_t               q_din,
  output ndsg_pkg::ram_wr_t            ram_wr
);
  import ndsg_pkg::*;

  in_item_t                           hold_r, hold_nxt;
  logic                               hold_v_r, hold_v_nxt;
  pos_vec_t                           pos_r, pos_nxt, pos_step;
  logic [MAX_DIMS-1:0][LEN_BITS-1:0]  len_r, len_nxt;
  logic [DEST_BITS-1:0]               dest_r, dest_nxt;
  logic                               carry;
  logic                               proceed;
  logic                               accept;
  logic [LEN_BITS-1:0]                new_len;

  // List writes wait until no queued or running step can still read the list
  always_comb begin
    case (hold_r.operation)
      OP_WRITE_ENTRY: proceed = hold_v_r && stall.drained;
      OP_STEP:        proceed = hold_v_r && !stall.q_full;
      default:        proceed = hold_v_r;
    endcase
  end

  assign full   = hold_v_r && !proceed;
  assign accept = push && !full;

  always_comb begin
    hold_nxt   = accept ? in_data : hold_r;
    hold_v_nxt = accept ? 1'b1 : (proceed ? 1'b0 : hold_v_r);
  end

  // Odometer advance, last dimension fastest
  always_comb begin
    logic [LEN_BITS-1:0] v;
    logic                c;
    c        = 1'b1;
    pos_step = pos_r;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      v = LEN_BITS'(pos_r[i]) + LEN_BITS'(c);
      if (i < int'(dims)) begin
        if (v >= len_r[i]) begin
          pos_step[i] = '0;
          c           = 1'b1;
        end else begin
          pos_step[i] = v[POS_BITS-1:0];
          c           = 1'b0;
        end
      end
    end
    carry = c;
  end

  // Clamp a new list length to 1..MAX_LIST_LEN
  always_comb begin
    if (hold_r.write_value == '0) begin
      new_len = LEN_BITS'(1);
    end else if (hold_r.write_value > WVAL_BITS'(MAX_LIST_LEN)) begin
      new_len = LEN_BITS'(MAX_LIST_LEN);
    end else begin
      new_len = hold_r.write_value[LEN_BITS-1:0];
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    dest_nxt = dest_r;
    if (proceed) begin
      case (hold_r.operation)
        OP_SET_LEN: begin
          len_nxt[hold_r.dim_select[DIM_BITS-1:0]] = new_len;
        end
        OP_REWIND: begin
          pos_nxt  = '0;
          dest_nxt = '0;
        end
        OP_STEP: begin
          if (carry) begin
            pos_nxt  = '0;
            dest_nxt = '0;
          end else begin
            pos_nxt  = pos_step;
            dest_nxt = dest_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign ram_wr.we   = proceed && (hold_r.operation == OP_WRITE_ENTRY);
  assign ram_wr.addr = {hold_r.dim_select[DIM_BITS-1:0], hold_r.list_position[POS_BITS-1:0]};
  assign ram_wr.data = hold_r.write_value[INDEX_BITS-1:0];

  assign q_push     = proceed && (hold_r.operation == OP_STEP);
  assign q_din.pos  = pos_r;
  assign q_din.dest = dest_r;
  assign q_din.last = carry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      pos_r    <= '0;
      dest_r   <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        len_r[i] <= LEN_BITS'(1);
      end
    end else begin
      hold_v_r <= hold_v_nxt;
      pos_r    <= pos_nxt;
      dest_r   <= dest_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

FILE: src/ndsg_back.sv
// ----------------------------------------------------------------------------
// ndsg_back
// Offset datapath: one list lookup and one Horner multiply-add per dimension,
// then a result register toward the output queue interface.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndsg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  ndsg_pkg::job_t                      q_dout,
  output logic                                q_pop,
  input  logic [ndsg_pkg::DIMS_W-1:0]         dims,
  input  ndsg_pkg::ext_vec_t                  ext,
  output logic [ndsg_pkg::RAM_ADDR_BITS-1:0]  ram_raddr,
  input  logic [ndsg_pkg::INDEX_BITS-1:0]     ram_rdata,
  output ndsg_pkg::out_item_t                 out_data,
  output logic                                empty,
  input  logic                                pop,
  output logic                                busy
);
  import ndsg_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [DIM_BITS-1:0]          cnt_r, cnt_nxt, cnt_inc;
  job_t                         job_r, job_nxt;
  logic [SRC_BITS-1:0]          acc_r, acc_nxt;
  logic                         oor_r, oor_nxt;
  logic                         out_v_r, out_v_nxt;
  out_item_t                    out_r, out_nxt;
  logic [EXT_BITS-1:0]          ext_cur;
  logic [SRC_BITS+EXT_BITS-1:0] prod;
  logic                         last_dim;
  logic                         out_free;

  assign cnt_inc  = cnt_r + 1'b1;
  assign last_dim = (DIMS_W'(cnt_r) + DIMS_W'(1)) == dims;
  assign ext_cur  = ext[cnt_r];
  assign prod     = acc_r * ext_cur;
  assign out_free = !out_v_r || pop;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    job_nxt   = job_r;
    acc_nxt   = acc_r;
    oor_nxt   = oor_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !pop;
    q_pop     = 1'b0;
    ram_raddr = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_dout;
          cnt_nxt   = '0;
          oor_nxt   = 1'b0;
          ram_raddr = {DIM_BITS'(0), q_dout.pos[0]};
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (cnt_r == '0) begin
          acc_nxt = SRC_BITS'(ram_rdata);
        end else begin
          acc_nxt = prod[SRC_BITS-1:0] + SRC_BITS'(ram_rdata);
        end
        oor_nxt = oor_r || (EXT_BITS'(ram_rdata) >= ext_cur);
        if (last_dim) begin
          state_nxt = B_DONE;
        end else begin
          cnt_nxt   = cnt_inc;
          ram_raddr = {cnt_inc, job_r.pos[cnt_inc]};
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_nxt.src_offset   = acc_r;
          out_nxt.dest_offset  = job_r.dest;
          out_nxt.out_of_range = oor_r;
          out_nxt.last         = job_r.last;
          out_v_nxt            = 1'b1;
          state_nxt            = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign busy     = (state_r != B_IDLE);
  assign empty    = !out_v_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    job_r <= job_nxt;
    acc_r <= acc_nxt;
    oor_r <= oor_nxt;
    out_r <= out_nxt;
  end

  `ASSERT_NEVER(a_cnt_in_range, clk, rst_n, (state_r == B_RUN) && (DIMS_W'(cnt_r) >= dims), "dimension counter beyond dimensions in use")
  `ASSERT_PROP(a_done_delivers, clk, rst_n, (state_r == B_DONE) && out_free |=> !empty, "finished offset not presented")

endmodule

FILE: src/nd_slice_gather_address_generator.sv
// ----------------------------------------------------------------------------
// nd_slice_gather_address_generator
// Row-major gather offset generator for an N-dimensional slice.
// ----------------------------------------------------------------------------
// A step passes the hold register, the job queue, the back-end lookup loop
// and the result register. List, length and rewind transactions are applied
// from the hold register (a list write first waits for queued and running
// steps to drain); steps share one lookup and multiply-add loop, one at a time.
// Reset (synchronous, rst_n low): one dimension, extents one, list lengths one,
// walk at zero; index lists keep their contents and must be written before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nd_slice_gather_address_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transaction queue side
  input  logic                                 push,
  output logic                                 full,
  input  ndsg_pkg::in_item_t                   in_data,
  // result queue side
  output logic                                 empty,
  input  logic                                 pop,
  output ndsg_pkg::out_item_t                  out_data,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ndsg_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [ndsg_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [ndsg_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import ndsg_pkg::*;

  // Configuration registers
  logic [CFG_DIMS_BITS-1:0] dims_r;
  ext_vec_t                 ext_r;
  logic [DIMS_W-1:0]        dims_eff;
  logic                     cfg_wr;
  logic [CFG_IDX_BITS-1:0]  reg_idx;

  // Front to back plumbing
  logic                     q_push, q_pop, q_full, q_empty;
  job_t                     q_din, q_dout;
  ram_wr_t                  ram_wr;
  logic [RAM_ADDR_BITS-1:0] ram_raddr;
  logic [INDEX_BITS-1:0]    ram_rdata;
  logic                     back_busy;
  front_stall_t             stall;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];

  // Clamp the dimension count: zero acts as one, anything above the maximum
  // acts as the maximum.
  always_comb begin
    if (dims_r == '0) begin
      dims_eff = DIMS_W'(1);
    end else if (dims_r > CFG_DIMS_BITS'(MAX_DIMS)) begin
      dims_eff = DIMS_W'(MAX_DIMS);
    end else begin
      dims_eff = DIMS_W'(dims_r);
    end
  end

  // Register writes; an address past the register list drops the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= CFG_DIMS_BITS'(1);
      for (int i = 0; i < MAX_DIMS; i++) begin
        ext_r[i] <= EXT_BITS'(1);
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DIMS: dims_r   <= pwdata[CFG_DIMS_BITS-1:0];
        REG_EXT0: ext_r[0] <= pwdata[EXT_BITS-1:0];
        REG_EXT1: ext_r[1] <= pwdata[EXT_BITS-1:0];
        REG_EXT2: ext_r[2] <= pwdata[EXT_BITS-1:0];
        REG_EXT3: ext_r[3] <= pwdata[EXT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the stored register value
  always_comb begin
    case (reg_idx)
      REG_DIMS: prdata = CFG_DATA_BITS'(dims_r);
      REG_EXT0: prdata = CFG_DATA_BITS'(ext_r[0]);
      REG_EXT1: prdata = CFG_DATA_BITS'(ext_r[1]);
      REG_EXT2: prdata = CFG_DATA_BITS'(ext_r[2]);
      REG_EXT3: prdata = CFG_DATA_BITS'(ext_r[3]);
      default:  prdata = '0;
    endcase
  end

  // Hold list writes while any step is queued or in the back end, so a step
  // always sees the lists as they stood when it was accepted.
  assign stall.q_full  = q_full;
  assign stall.drained = q_empty && !back_busy;

  ndsg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .dims    (dims_eff),
    .stall   (stall),
    .q_push  (q_push),
    .q_din   (q_din),
    .ram_wr  (ram_wr)
  );

  ndsg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Index lists: one row of MAX_LIST_LEN entries per dimension
  ndsg_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_lists (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ndsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .dims      (dims_eff),
    .ext       (ext_r),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop),
    .busy      (back_busy)
  );

  `ASSERT_NEVER(a_list_write_hazard, clk, rst_n, ram_wr.we && (back_busy || !q_empty), "index list written while a step is pending")

endmodule
